[sv/cusum_pkg.sv]
`default_nettype none
package cusum_pkg;

  // default values of the top level parameters
  localparam int unsigned DEF_MAX_WINDOW  = 1024;
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_INDEX_BITS  = 48;

  // fixed field widths
  localparam int unsigned IDX_OUT_W  = 48;
  localparam int unsigned UPPER_W    = 31;
  localparam int unsigned LOWER_W    = 32;
  localparam int unsigned WIN_W      = 11;
  localparam int unsigned THR_W      = 31;
  localparam int unsigned DRIFT_W    = 24;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = CFG_IDX_W'(3);

  // register reset values
  localparam logic [WIN_W-1:0]          RST_WINDOW    = WIN_W'(16);
  localparam logic [THR_W-1:0]          RST_THRESHOLD = THR_W'(1280);
  localparam logic signed [DRIFT_W-1:0] RST_DRIFT     = DRIFT_W'(128);
  localparam logic [HOLD_W-1:0]         RST_HOLDOFF   = HOLD_W'(0);

  typedef enum logic [0:0] {
    ST_RUN,
    ST_DIV
  } cusum_state_t;

  typedef struct packed {
    logic step;
    logic div_step;
  } cusum_cmd_t;

  typedef struct packed {
    logic learn_done;
    logic div_last;
  } cusum_sts_t;

  typedef struct packed {
    logic                      event_res;
    logic [IDX_OUT_W-1:0]      sample_index;
    logic                      learning;
    logic [UPPER_W-1:0]        upper_sum;
    logic signed [LOWER_W-1:0] lower_sum;
  } cusum_res_t;

endpackage
`default_nettype wire

[sv/cusum_ctrl.sv]
`default_nettype none
module cusum_ctrl
  import cusum_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       q_full,
  input  wire cusum_sts_t sts,
  output cusum_cmd_t      cmd
);

  cusum_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.step     = 1'b0;
    cmd.div_step = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_ready = !q_full;
        cmd.step = in_valid && !q_full;
        // the sample that completes the window starts the mean division
        if (cmd.step && sts.learn_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/cusum_dp.sv]
`default_nettype none
module cusum_dp
  import cusum_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned INDEX_BITS  = DEF_INDEX_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire cusum_cmd_t                    cmd,
  output cusum_sts_t                         sts,
  output cusum_res_t                         res
);

  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CMP_W  = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int unsigned ACC_W  = SAMPLE_BITS + CNT_W;
  localparam int unsigned NUM_W  = ACC_W + 8;
  localparam int unsigned BCNT_W = $clog2(NUM_W);
  localparam int unsigned MEAN_W = SAMPLE_BITS + 9;
  localparam int unsigned DEV_W  = SAMPLE_BITS + 10;
  localparam int unsigned SUM_W  = ((DEV_W > 33) ? DEV_W : 33) + 2;

  localparam logic [CMP_W-1:0]        MAXW_C  = CMP_W'(MAX_WINDOW);
  localparam logic signed [SUM_W-1:0] POS_LIM = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] NEG_LIM = SUM_W'(-64'sd2147483648);

  // configuration
  logic [WIN_W-1:0]          window_r;
  logic [THR_W-1:0]          thr_r;
  logic signed [DRIFT_W-1:0] drift_r;
  logic [HOLD_W-1:0]         holdoff_r;

  // detector state
  logic [INDEX_BITS-1:0]     idx_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      mean_valid_r;
  logic signed [MEAN_W-1:0]  mean_r;
  logic [UPPER_W-1:0]        pos_r;
  logic signed [LOWER_W-1:0] neg_r;
  logic [HOLD_W-1:0]         hold_r;

  // mean divider
  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic              dneg_r;

  logic [CMP_W-1:0]          win;
  logic [CMP_W-1:0]          wl_ext;
  logic [CNT_W-1:0]          cnt_inc;
  logic signed [ACC_W-1:0]   acc_sum;
  logic [ACC_W-1:0]          acc_mag;
  logic [NUM_W-1:0]          num;
  logic [CNT_W:0]            rem_sh;
  logic [CNT_W:0]            trial;
  logic                      qbit;
  logic [CNT_W-1:0]          rem_nxt;
  logic [NUM_W-1:0]          quo_nxt;
  logic signed [MEAN_W-1:0]  mean_nxt;
  logic signed [DEV_W-1:0]   dev;
  logic signed [SUM_W-1:0]   p_sum;
  logic signed [SUM_W-1:0]   n_sum;
  logic [UPPER_W-1:0]        pos_new;
  logic signed [LOWER_W-1:0] neg_new;
  logic [LOWER_W:0]          neg_mag;
  logic                      hit;
  logic                      fire;

  always_comb begin
    wl_ext = CMP_W'(window_r);
    if (window_r == '0) begin
      win = CMP_W'(1);
    end else if (wl_ext > MAXW_C) begin
      win = MAXW_C;
    end else begin
      win = wl_ext;
    end
    cnt_inc = cnt_r + CNT_W'(1);
    acc_sum = acc_r + ACC_W'(in_sample);
    acc_mag = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
    // round half away from zero on the magnitude
    num = {acc_mag, 8'b0} + NUM_W'(cnt_inc >> 1);

    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    trial   = rem_sh - {1'b0, cnt_r};
    qbit    = !trial[CNT_W];
    rem_nxt = qbit ? trial[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], qbit};
    mean_nxt = dneg_r ? -$signed(MEAN_W'(quo_nxt)) : $signed(MEAN_W'(quo_nxt));

    dev   = (DEV_W'(in_sample) <<< 8) - DEV_W'(mean_r);
    p_sum = SUM_W'($signed({1'b0, pos_r})) + SUM_W'(dev) - SUM_W'(drift_r);
    n_sum = SUM_W'(neg_r) + SUM_W'(dev) + SUM_W'(drift_r);
    if (p_sum < 0) begin
      pos_new = '0;
    end else if (p_sum > POS_LIM) begin
      pos_new = '1;
    end else begin
      pos_new = p_sum[UPPER_W-1:0];
    end
    if (n_sum > 0) begin
      neg_new = '0;
    end else if (n_sum < NEG_LIM) begin
      neg_new = {1'b1, {(LOWER_W-1){1'b0}}};
    end else begin
      neg_new = n_sum[LOWER_W-1:0];
    end
    neg_mag = (LOWER_W+1)'(0) - {neg_new[LOWER_W-1], neg_new};
    hit  = ({1'b0, pos_new} >= {1'b0, thr_r}) || (neg_mag >= {2'b0, thr_r});
    fire = mean_valid_r && (hold_r == '0) && hit;

    sts.learn_done = !mean_valid_r && (CMP_W'(cnt_inc) >= win);
    sts.div_last   = (bcnt_r == '0);

    res.event_res    = fire;
    res.sample_index = IDX_OUT_W'(idx_r);
    res.learning     = !mean_valid_r;
    if (!mean_valid_r) begin
      res.upper_sum = pos_r;
      res.lower_sum = neg_r;
    end else if (fire) begin
      res.upper_sum = '0;
      res.lower_sum = '0;
    end else begin
      res.upper_sum = pos_new;
      res.lower_sum = neg_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= RST_WINDOW;
      thr_r     <= RST_THRESHOLD;
      drift_r   <= RST_DRIFT;
      holdoff_r <= RST_HOLDOFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW:    window_r  <= cfg_data[WIN_W-1:0];
        REG_THRESHOLD: thr_r     <= cfg_data[THR_W-1:0];
        REG_DRIFT:     drift_r   <= $signed(cfg_data[DRIFT_W-1:0]);
        REG_HOLDOFF:   holdoff_r <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      acc_r        <= '0;
      cnt_r        <= '0;
      mean_valid_r <= 1'b0;
      pos_r        <= '0;
      neg_r        <= '0;
      hold_r       <= '0;
    end else begin
      if (cmd.step) begin
        idx_r <= idx_r + INDEX_BITS'(1);
        if (!mean_valid_r) begin
          acc_r <= acc_sum;
          cnt_r <= cnt_inc;
        end else if (hold_r != '0) begin
          pos_r  <= pos_new;
          neg_r  <= neg_new;
          hold_r <= hold_r - HOLD_W'(1);
        end else if (hit) begin
          pos_r  <= '0;
          neg_r  <= '0;
          hold_r <= holdoff_r;
        end else begin
          pos_r <= pos_new;
          neg_r <= neg_new;
        end
      end
      if (cmd.div_step && sts.div_last) begin
        mean_valid_r <= 1'b1;
      end
    end
  end

  // divider payload, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.step && sts.learn_done) begin
      quo_r  <= num;
      rem_r  <= '0;
      bcnt_r <= BCNT_W'(NUM_W - 1);
      dneg_r <= acc_sum[ACC_W-1];
    end else if (cmd.div_step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      bcnt_r <= bcnt_r - BCNT_W'(1);
      if (sts.div_last) begin
        mean_r <= mean_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[sv/cusum_oq.sv]
`default_nettype none
module cusum_oq
  import cusum_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire cusum_res_t push_data,
  output logic            full,
  output logic            out_valid,
  input  wire logic       out_ready,
  output cusum_res_t      out_data
);

  cusum_res_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

[sv/cusum_change_detector.sv]
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_sample
// out       output     out_valid / out_ready  event_res, sample_index, learning, sums
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one sample per cycle while the two-entry result queue has room
// the sample that completes the baseline window starts the mean divider, which
// produces one quotient bit per cycle, with in_ready low; this happens once
// after reset
// synchronous active-low reset, no memory clearing; cfg_ready is always high
`default_nettype none
module cusum_change_detector
  import cusum_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = DEF_MAX_WINDOW,
  parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int unsigned INDEX_BITS  = DEF_INDEX_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_event_res,
  output logic [IDX_OUT_W-1:0]               out_sample_index,
  output logic                               out_learning,
  output logic [UPPER_W-1:0]                 out_upper_sum,
  output logic signed [LOWER_W-1:0]          out_lower_sum
);

  cusum_cmd_t cmd;
  cusum_sts_t sts;
  cusum_res_t res;
  cusum_res_t q_data;
  logic       q_full;

  assign cfg_ready = 1'b1;

  cusum_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .sts      (sts),
    .cmd      (cmd)
  );

  cusum_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_sample),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res)
  );

  cusum_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd.step),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (q_data)
  );

  assign out_event_res    = q_data.event_res;
  assign out_sample_index = q_data.sample_index;
  assign out_learning     = q_data.learning;
  assign out_upper_sum    = q_data.upper_sum;
  assign out_lower_sum    = q_data.lower_sum;

endmodule
`default_nettype wire

[sv/cusum_checker.sv]
`default_nettype none
module cusum_checker
  import cusum_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_event_res,
  input wire logic [IDX_OUT_W-1:0]      out_sample_index,
  input wire logic                      out_learning,
  input wire logic [UPPER_W-1:0]        out_upper_sum,
  input wire logic signed [LOWER_W-1:0] out_lower_sum
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_index)
      && $stable(out_upper_sum) && $stable(out_lower_sum))
    else $error("result changed while stalled");

  // no detection while the baseline is collected
  a_event_not_learning: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res |-> !out_learning)
    else $error("event during learning");

  // an event clears both sums
  a_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res |-> out_upper_sum == '0 && out_lower_sum == '0)
    else $error("sums not cleared on event");

  // results follow each other with consecutive indexes
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid && !out_learning && $past(!out_learning)
      |-> out_sample_index == $past(out_sample_index) + IDX_OUT_W'(1))
    else $error("sample index skipped");

endmodule

bind cusum_change_detector cusum_checker u_cusum_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_res    (out_event_res),
  .out_sample_index (out_sample_index),
  .out_learning     (out_learning),
  .out_upper_sum    (out_upper_sum),
  .out_lower_sum    (out_lower_sum)
);
`default_nettype wire

[dv/cusum_result_check.sv]
module cusum_result_check
  import cusum_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [DEF_SAMPLE_BITS-1:0] in_sample,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_event_res,
  input  logic [IDX_OUT_W-1:0]              out_sample_index,
  input  logic                              out_learning,
  input  logic [UPPER_W-1:0]                out_upper_sum,
  input  logic signed [LOWER_W-1:0]         out_lower_sum,
  output int                                mismatch_count,
  output int                                pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  // register copies
  logic [WIN_W-1:0]          win_len;
  logic [THR_W-1:0]          thr_q8;
  logic signed [DRIFT_W-1:0] drift_q8;
  logic [HOLD_W-1:0]         hold_len;

  // detector state
  logic [IDX_OUT_W-1:0] idx_count;
  longint               base_sum;
  longint               base_cnt;
  bit                   mean_ok;
  longint               mean_q8;
  longint               up_sum;
  longint               dn_sum;
  logic [HOLD_W-1:0]    hold_left;

  cusum_res_t predicted_outcomes[$];
  int         mismatch_total = 0;

  function automatic longint clip32(input longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  function automatic cusum_res_t step_detector(input logic signed [DEF_SAMPLE_BITS-1:0] smp);
    cusum_res_t r;
    longint     x;
    longint     win;
    longint     num;
    longint     dev;
    longint     p;
    longint     n;
    r = '0;
    x = longint'(smp);
    r.sample_index = idx_count;
    idx_count = idx_count + 1'b1;
    if (!mean_ok) begin
      r.learning = 1'b1;
      win = longint'(win_len);
      if (win == 0) win = 1;
      if (win > longint'(DEF_MAX_WINDOW)) win = longint'(DEF_MAX_WINDOW);
      base_sum += x;
      base_cnt++;
      if (base_cnt >= win) begin
        // q.8 mean, rounded half away from zero
        num = base_sum * 256;
        if (num >= 0) mean_q8 = (num + base_cnt / 2) / base_cnt;
        else mean_q8 = -((-num + base_cnt / 2) / base_cnt);
        mean_ok = 1'b1;
      end
    end else begin
      dev = x * 256 - mean_q8;
      p = clip32(up_sum + dev - longint'(drift_q8));
      n = clip32(dn_sum + dev + longint'(drift_q8));
      up_sum = (p < 0) ? 0 : p;
      dn_sum = (n > 0) ? 0 : n;
      if (hold_left != '0) begin
        hold_left = hold_left - 1'b1;
      end else if (up_sum >= longint'(thr_q8) || -dn_sum >= longint'(thr_q8)) begin
        r.event_res = 1'b1;
        up_sum = 0;
        dn_sum = 0;
        hold_left = hold_len;
      end
    end
    r.upper_sum = up_sum[UPPER_W-1:0];
    r.lower_sum = dn_sum[LOWER_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $realtime, msg);
    mismatch_total++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want,
                             input logic [IDX_OUT_W-1:0] at);
    if (got !== want)
      report_mismatch($sformatf("%s of sample %0d: got 0x%0h, want 0x%0h", name, at, got, want));
  endtask

  always @(posedge clk) begin
    cusum_res_t want;
    if (!rst_n) begin
      win_len   = RST_WINDOW;
      thr_q8    = RST_THRESHOLD;
      drift_q8  = RST_DRIFT;
      hold_len  = RST_HOLDOFF;
      idx_count = '0;
      base_sum  = 0;
      base_cnt  = 0;
      mean_ok   = 1'b0;
      mean_q8   = 0;
      up_sum    = 0;
      dn_sum    = 0;
      hold_left = '0;
      predicted_outcomes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW:    win_len  = cfg_data[WIN_W-1:0];
          REG_THRESHOLD: thr_q8   = cfg_data[THR_W-1:0];
          REG_DRIFT:     drift_q8 = cfg_data[DRIFT_W-1:0];
          REG_HOLDOFF:   hold_len = cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predicted_outcomes.insert(predicted_outcomes.size(), step_detector(in_sample));
      if (out_valid && out_ready) begin
        if (predicted_outcomes.size() == 0) begin
          report_mismatch($sformatf("result for sample %0d with nothing outstanding",
                                    out_sample_index));
        end else begin
          want = predicted_outcomes.pop_front();
          check_field("event_res", 64'(out_event_res), 64'(want.event_res), want.sample_index);
          check_field("sample_index", 64'(out_sample_index), 64'(want.sample_index),
                      want.sample_index);
          check_field("learning", 64'(out_learning), 64'(want.learning), want.sample_index);
          check_field("upper_sum", 64'(out_upper_sum), 64'(want.upper_sum), want.sample_index);
          check_field("lower_sum", 64'(out_lower_sum), 64'(want.lower_sum), want.sample_index);
        end
      end
    end
    mismatch_count  <= mismatch_total;
    pending_results <= predicted_outcomes.size();
  end

endmodule

[dv/cusum_change_detector_tb.sv]
module cusum_change_detector_tb
  import cusum_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);
  localparam logic [31:0] WIN_ABOVE_MAX = 32'h7FF;
  localparam logic [31:0] THR_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] DRIFT_MAX     = 32'h007F_FFFF;
  localparam logic [31:0] DRIFT_MIN     = 32'hFF80_0000;
  localparam logic [31:0] HOLD_MAX      = 32'h0000_FFFF;
  // covers the one-time mean division plus the output queue
  localparam int SETTLE_CYCLES = 48;

  typedef enum {SHAPE_NOISE, SHAPE_STEPS, SHAPE_SWING} sample_shape_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [CFG_IDX_W-1:0]              cfg_index = '0;
  logic [CFG_DATA_W-1:0]             cfg_data = '0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [DEF_SAMPLE_BITS-1:0] in_sample = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              out_event_res;
  logic [IDX_OUT_W-1:0]              out_sample_index;
  logic                              out_learning;
  logic [UPPER_W-1:0]                out_upper_sum;
  logic signed [LOWER_W-1:0]         out_lower_sum;
  int                                mismatch_count;
  int                                pending_results;

  int send_idle_pct = 34;
  int recv_idle_pct = 59;

  cusum_change_detector dut (.*);

  cusum_result_check result_check (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // valid stays high after the transfer; the caller lowers it
  task automatic feed_sample(input logic signed [DEF_SAMPLE_BITS-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // unused upper data bits carry junk, plus one write to an unmapped index
  task automatic program_detector(input logic [31:0] win, input logic [31:0] thr,
                                  input logic [31:0] drift, input logic [31:0] hold);
    logic [CFG_IDX_W-1:0]  idx_list [5];
    logic [CFG_DATA_W-1:0] val_list [5];
    int                    k;
    idx_list = '{REG_WINDOW, REG_THRESHOLD, REG_DRIFT, REG_HOLDOFF, REG_UNUSED};
    val_list[0] = {21'($urandom), win[WIN_W-1:0]};
    val_list[1] = {1'($urandom), thr[THR_W-1:0]};
    val_list[2] = {8'($urandom), drift[DRIFT_W-1:0]};
    val_list[3] = {16'($urandom), hold[HOLD_W-1:0]};
    val_list[4] = $urandom;
    for (k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data  <= val_list[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input sample_shape_t shape, input int n);
    int k;
    int v;
    int level;
    int span;
    int amp;
    level = 0;
    span  = 0;
    amp   = 0;
    for (k = 0; k < n; k++) begin
      case (shape)
        SHAPE_NOISE: v = int'($urandom_range(65535)) - 32768;
        // pinned near full scale: first half drives the upper sum, second the lower
        SHAPE_SWING: v = (k < n / 2) ? 32767 - int'($urandom_range(400))
                                     : -32768 + int'($urandom_range(400));
        default: begin
          if (span == 0) begin
            span  = $urandom_range(40, 8);
            level = int'($urandom_range(40000)) - 20000;
            amp   = ($urandom_range(3) == 0) ? 4095 : 255;
          end
          span--;
          v = level + int'($urandom_range(2 * amp)) - amp;
        end
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      feed_sample(DEF_SAMPLE_BITS'(v));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // baseline: window above the maximum, then cut to zero below the count collected
    program_detector(WIN_ABOVE_MAX, 32'(RST_THRESHOLD), 32'(RST_DRIFT), 32'(RST_HOLDOFF));
    feed_sample(16'sh7FFF); feed_sample(-16'sh8000); feed_sample(16'sd0);
    feed_sample(-16'sd1); feed_sample(16'sd1);
    settle();
    program_detector(32'd0, 32'(RST_THRESHOLD), 32'(RST_DRIFT), 32'(RST_HOLDOFF));
    feed_sample(16'sd12345);
    settle();

    program_detector(32'd16, 32'd1280, 32'd128, 32'd0);
    feed_sample(16'sd2057); feed_sample(16'sd2100); feed_sample(16'sd1900);
    feed_sample(16'sd2057);
    settle();

    // zero threshold: every sample outside holdoff fires
    program_detector(WIN_ABOVE_MAX, 32'd0, 32'd0, 32'd2);
    feed_sample(16'sh7FFF); feed_sample(-16'sh8000); feed_sample(16'sd0);
    feed_sample(16'sd1); feed_sample(-16'sd1); feed_sample(16'sh7FFF);
    settle();

    program_detector(32'd0, 32'd1, DRIFT_MAX, 32'd0);
    feed_sample(16'sh7FFF); feed_sample(-16'sh8000); feed_sample(16'sd100);
    settle();

    program_detector(32'($urandom), $urandom_range(200000, 1000), $urandom_range(4000),
                     $urandom_range(20));
    run_phase(SHAPE_STEPS, 150);
    settle();
    program_detector(32'($urandom), 32'd0, 32'(int'($urandom_range(8000)) - 4000), 32'd3);
    run_phase(SHAPE_NOISE, 60);
    settle();
    // both sums run into saturation
    program_detector(32'($urandom), THR_MAX, DRIFT_MIN, 32'd0);
    run_phase(SHAPE_SWING, 290);
    settle();

    send_idle_pct = 59;
    recv_idle_pct = 34;
    program_detector(32'($urandom), $urandom_range(5000, 1), DRIFT_MAX, 32'd0);
    run_phase(SHAPE_NOISE, 80);
    settle();
    program_detector(32'($urandom), $urandom_range(100000, 500),
                     32'(-int'($urandom_range(3000))), $urandom_range(10));
    run_phase(SHAPE_STEPS, 150);
    settle();
    program_detector(32'($urandom), 32'd1, 32'd0, 32'd1);
    run_phase(SHAPE_NOISE, 60);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_detector(32'($urandom), $urandom_range(300000, 1),
                     32'(int'($urandom_range(20000)) - 10000), $urandom_range(30));
    run_phase(SHAPE_STEPS, 200);
    settle();
    // long holdoff goes last since it mutes detection for the rest of the run
    program_detector(32'($urandom), $urandom_range(50000, 1000), $urandom_range(2000),
                     HOLD_MAX);
    run_phase(SHAPE_STEPS, 100);
    settle();

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
